[hw/rtl/bvag_pkg.sv]
// ----------------------------------------------------------------------------
// bvag_pkg
// Shared constants for the bricked volume address generator.
// ----------------------------------------------------------------------------
package bvag_pkg;

	// config field widths
	localparam int unsigned IEDGE_W = 4;
	localparam int unsigned OEDGE_W = 6;
	localparam int unsigned SIZE_W  = 13;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_INNER_EDGE = 3'd0;
	localparam logic [2:0] REG_OUTER_EDGE = 3'd1;
	localparam logic [2:0] REG_SIZE_X     = 3'd2;
	localparam logic [2:0] REG_SIZE_Y     = 3'd3;
	localparam logic [2:0] REG_SIZE_Z     = 3'd4;
	localparam logic [2:0] REG_SBRICK_Y   = 3'd5;
	localparam logic [2:0] REG_SBRICK_Z   = 3'd6;

	// number of weighted digits summed into the offset (3 axes x 3 levels)
	localparam int unsigned NUM_TERMS = 9;

endpackage

[hw/rtl/bvag_div.sv]
// ----------------------------------------------------------------------------
// bvag_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bvag_div #(
	parameter int unsigned NW = 12,
	parameter int unsigned DW = 4,
	parameter int unsigned SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][NW-1:0]    num,
	input  logic [DW-1:0]         den,
	input  logic [SW-1:0]         side_in,
	output logic                  out_valid,
	output logic [2:0][NW-1:0]    quo,
	output logic [2:0][DW-1:0]    rem,
	output logic [SW-1:0]         side_out
);

	logic                 valid_s [NW];
	logic [2:0][NW-1:0]   qn_s    [NW];
	logic [2:0][DW-1:0]   rem_s   [NW];
	logic [SW-1:0]        side_s  [NW];

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_stage
			logic               cur_v;
			logic [2:0][NW-1:0] cur_qn;
			logic [2:0][DW-1:0] cur_rem;
			logic [SW-1:0]      cur_side;
			logic [2:0][NW-1:0] nxt_qn;
			logic [2:0][DW-1:0] nxt_rem;

			if (k == 0) begin : g_first
				assign cur_v    = in_valid;
				assign cur_qn   = num;
				assign cur_rem  = '0;
				assign cur_side = side_in;
			end else begin : g_rest
				assign cur_v    = valid_s[k-1];
				assign cur_qn   = qn_s[k-1];
				assign cur_rem  = rem_s[k-1];
				assign cur_side = side_s[k-1];
			end

			// shift in the next numerator bit, subtract when it fits
			always_comb begin
				logic [DW:0] trial;
				logic        ge;
				for (int l = 0; l < 3; l++) begin
					trial = {cur_rem[l], cur_qn[l][NW-1]};
					ge    = (trial >= {1'b0, den});
					nxt_rem[l] = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
					nxt_qn[l]  = {cur_qn[l][NW-2:0], ge};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= cur_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					qn_s[k]   <= nxt_qn;
					rem_s[k]  <= nxt_rem;
					side_s[k] <= cur_side;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[NW-1];
	assign quo       = qn_s[NW-1];
	assign rem       = rem_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

[hw/rtl/bvag_mac.sv]
// ----------------------------------------------------------------------------
// bvag_mac
// Weighs nine digits by their strides and sums them into the element offset.
// ----------------------------------------------------------------------------
module bvag_mac #(
	parameter int unsigned NW = 12,
	parameter int unsigned OW = 37
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic                                    oor,
	input  logic [bvag_pkg::NUM_TERMS-1:0][NW-1:0]  dig,
	input  logic [bvag_pkg::NUM_TERMS-1:0][OW-1:0]  stride,
	output logic                                    out_valid,
	output logic [OW-1:0]                           offset,
	output logic                                    out_oor
);

	localparam int unsigned HW = (OW + 1) / 2;
	localparam int unsigned NT = bvag_pkg::NUM_TERMS;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      oor_s1, oor_s2, oor_s3, oor_s4;
	logic [NT-1:0][NW+HW-1:0]    plo_s1;
	logic [NT-1:0][NW+OW-HW-1:0] phi_s1;
	logic [NT-1:0][OW-1:0]     term_s2;
	logic [2:0][OW-1:0]        axis_s3;
	logic [OW-1:0]             off_s4;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s1: split products, s2: recombine, s3: per-axis sums, s4: total
	always_ff @(posedge clk) begin
		if (en) begin
			oor_s1 <= oor;
			oor_s2 <= oor_s1;
			oor_s3 <= oor_s2;
			oor_s4 <= oor_s3;
			for (int t = 0; t < NT; t++) begin
				plo_s1[t]  <= (NW+HW)'(dig[t]) * (NW+HW)'(stride[t][HW-1:0]);
				phi_s1[t]  <= (NW+OW-HW)'(dig[t]) * (NW+OW-HW)'(stride[t][OW-1:HW]);
				term_s2[t] <= OW'(plo_s1[t]) + (OW'(phi_s1[t]) << HW);
			end
			for (int a = 0; a < 3; a++) begin
				axis_s3[a] <= term_s2[3*a] + term_s2[3*a+1] + term_s2[3*a+2];
			end
			off_s4 <= oor_s3 ? '0 : (axis_s3[0] + axis_s3[1] + axis_s3[2]);
		end
	end

	assign out_valid = valid_s4;
	assign offset    = off_s4;
	assign out_oor   = oor_s4;

endmodule

[hw/rtl/bricked_volume_address_gen_core.sv]
// Each word passes the inner divider, the outer divider and the multiply-add stages.
// Throughput: one word per cycle; the two digit-split dividers and the stride
// multipliers are fully pipelined, a stall at the output freezes the whole pipe.
// Strides are rebuilt from the config registers by a free-running multiply chain.
// Reset (arst_n low, asynchronous) empties the pipe and loads the register defaults.
// ----------------------------------------------------------------------------
// bricked_volume_address_gen_core
// Maps a voxel coordinate to its offset in a two-level bricked volume.
// ----------------------------------------------------------------------------
module bricked_volume_address_gen_core #(
	parameter int unsigned COORD_BITS  = 12,
	parameter int unsigned OFFSET_BITS = 37
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// input words
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// coord_x, coord_y, coord_z (low bits up), zero padded
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]         s_tdata,
	// result words
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// element_offset, zero padded
	output logic [((OFFSET_BITS+7)/8)*8-1:0]          m_tdata,
	// out_of_range
	output logic                                      m_tuser,
	// config port
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [4:0]                                paddr,
	input  logic [31:0]                               pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready
);

	localparam int unsigned NW  = COORD_BITS;
	localparam int unsigned OW  = OFFSET_BITS;
	localparam int unsigned IEW = bvag_pkg::IEDGE_W;
	localparam int unsigned OEW = bvag_pkg::OEDGE_W;
	localparam int unsigned SZW = bvag_pkg::SIZE_W;
	localparam int unsigned NT  = bvag_pkg::NUM_TERMS;

	// config registers
	logic [IEW-1:0] inner_edge_q;
	logic [OEW-1:0] outer_edge_q;
	logic [SZW-1:0] size_x_q, size_y_q, size_z_q, sbrick_y_q, sbrick_z_q;
	logic [2:0]     reg_idx;
	logic           cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_edge_q <= IEW'(3);
			outer_edge_q <= OEW'(5);
			size_x_q     <= SZW'(4096);
			size_y_q     <= SZW'(4096);
			size_z_q     <= SZW'(4096);
			sbrick_y_q   <= SZW'(1);
			sbrick_z_q   <= SZW'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				bvag_pkg::REG_INNER_EDGE: inner_edge_q <= pwdata[IEW-1:0];
				bvag_pkg::REG_OUTER_EDGE: outer_edge_q <= pwdata[OEW-1:0];
				bvag_pkg::REG_SIZE_X:     size_x_q     <= pwdata[SZW-1:0];
				bvag_pkg::REG_SIZE_Y:     size_y_q     <= pwdata[SZW-1:0];
				bvag_pkg::REG_SIZE_Z:     size_z_q     <= pwdata[SZW-1:0];
				bvag_pkg::REG_SBRICK_Y:   sbrick_y_q   <= pwdata[SZW-1:0];
				bvag_pkg::REG_SBRICK_Z:   sbrick_z_q   <= pwdata[SZW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			bvag_pkg::REG_INNER_EDGE: prdata = 32'(inner_edge_q);
			bvag_pkg::REG_OUTER_EDGE: prdata = 32'(outer_edge_q);
			bvag_pkg::REG_SIZE_X:     prdata = 32'(size_x_q);
			bvag_pkg::REG_SIZE_Y:     prdata = 32'(size_y_q);
			bvag_pkg::REG_SIZE_Z:     prdata = 32'(size_z_q);
			bvag_pkg::REG_SBRICK_Y:   prdata = 32'(sbrick_y_q);
			bvag_pkg::REG_SBRICK_Z:   prdata = 32'(sbrick_z_q);
			default:                  prdata = '0;
		endcase
	end

	// zero edges count as one
	logic [IEW-1:0] e_eff;
	logic [OEW-1:0] o_eff;
	assign e_eff = (inner_edge_q == '0) ? IEW'(1) : inner_edge_q;
	assign o_eff = (outer_edge_q == '0) ? OEW'(1) : outer_edge_q;

	// stride chain, one multiply per register
	logic [7:0]  e2_q;
	logic [11:0] o2_q;
	logic [25:0] yz_q;
	logic [11:0] b_q;
	logic [17:0] ob_q;
	logic [23:0] o2b_q;
	logic [29:0] sb_q;
	logic [42:0] zsb_q;
	logic [55:0] yzsb_q;

	always_ff @(posedge clk) begin
		e2_q   <= 8'(e_eff) * 8'(e_eff);
		o2_q   <= 12'(o_eff) * 12'(o_eff);
		yz_q   <= 26'(sbrick_y_q) * 26'(sbrick_z_q);
		b_q    <= 12'(e2_q) * 12'(e_eff);
		ob_q   <= 18'(b_q) * 18'(o_eff);
		o2b_q  <= 24'(b_q) * 24'(o2_q);
		sb_q   <= 30'(o2b_q) * 30'(o_eff);
		zsb_q  <= 43'(sb_q) * 43'(sbrick_z_q);
		yzsb_q <= 56'(sb_q) * 56'(yz_q);
	end

	// handshake: the whole pipe advances unless the output word is stuck
	logic en;
	logic in_acc;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign in_acc   = s_tvalid && s_tready;

	logic [2:0][NW-1:0] coord;
	logic               oor_in;
	assign coord[0] = s_tdata[NW-1:0];
	assign coord[1] = s_tdata[2*NW-1:NW];
	assign coord[2] = s_tdata[3*NW-1:2*NW];
	assign oor_in   = (32'(coord[0]) >= 32'(size_x_q)) ||
	                  (32'(coord[1]) >= 32'(size_y_q)) ||
	                  (32'(coord[2]) >= 32'(size_z_q));

	// split by the inner edge: fine digit and rest
	logic               d1_valid, d1_oor;
	logic [2:0][NW-1:0] d1_rest;
	logic [2:0][IEW-1:0] d1_fine;

	bvag_div #(.NW(NW), .DW(IEW), .SW(1)) u_div_inner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_acc),
		.num      (coord),
		.den      (e_eff),
		.side_in  (oor_in),
		.out_valid(d1_valid),
		.quo      (d1_rest),
		.rem      (d1_fine),
		.side_out (d1_oor)
	);

	// split the rest by the outer edge: middle and superbrick digits
	logic                  d2_valid;
	logic [3*IEW:0]        d2_side;
	logic [2:0][NW-1:0]    d2_sup;
	logic [2:0][OEW-1:0]   d2_mid;

	bvag_div #(.NW(NW), .DW(OEW), .SW(3*IEW+1)) u_div_outer (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (d1_valid),
		.num      (d1_rest),
		.den      (o_eff),
		.side_in  ({d1_oor, d1_fine}),
		.out_valid(d2_valid),
		.quo      (d2_sup),
		.rem      (d2_mid),
		.side_out (d2_side)
	);

	// digits and strides, x then y then z, superbrick/middle/fine per axis
	logic [NT-1:0][NW-1:0] dig;
	logic [NT-1:0][OW-1:0] stride;
	logic [2:0][IEW-1:0]   fine;
	assign fine = d2_side[3*IEW-1:0];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dig[3*a]   = d2_sup[a];
			dig[3*a+1] = NW'(d2_mid[a]);
			dig[3*a+2] = NW'(fine[a]);
		end
		stride[0] = OW'(yzsb_q);
		stride[1] = OW'(o2b_q);
		stride[2] = OW'(e2_q);
		stride[3] = OW'(zsb_q);
		stride[4] = OW'(ob_q);
		stride[5] = OW'(e_eff);
		stride[6] = OW'(sb_q);
		stride[7] = OW'(b_q);
		stride[8] = OW'(1);
	end

	logic [OW-1:0] offset;
	logic          oor_out;

	bvag_mac #(.NW(NW), .OW(OW)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (d2_valid),
		.oor      (d2_side[3*IEW]),
		.dig      (dig),
		.stride   (stride),
		.out_valid(m_tvalid),
		.offset   (offset),
		.out_oor  (oor_out)
	);

	assign m_tdata = ($bits(m_tdata))'(offset);
	assign m_tuser = oor_out;

	// an out-of-range word always carries a zero offset
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> offset == '0)
		else $error("out-of-range word with nonzero offset");

	// fine digits leaving the first divider are below the inner edge
	a_fine_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d1_valid |-> (d1_fine[0] < e_eff) && (d1_fine[1] < e_eff) && (d1_fine[2] < e_eff))
		else $error("inner digit not below inner edge");

	// middle digits leaving the second divider are below the outer edge
	a_mid_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid |-> (d2_mid[0] < o_eff) && (d2_mid[1] < o_eff) && (d2_mid[2] < o_eff))
		else $error("middle digit not below outer edge");

endmodule

[dv/bricked_volume_address_gen_core_tb.sv]
// ----------------------------------------------------------------------------
// bricked_volume_address_gen_core_tb
// Streams voxel coordinates through the address generator under several brick
// and volume settings, predicts each offset and range flag, and checks every
// result word in order. Both stream sides idle at random, and the result side
// holds off once long enough to back up the pipe.
// ----------------------------------------------------------------------------
module bricked_volume_address_gen_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CB      = 12;
	localparam int unsigned OB      = 37;
	localparam int unsigned LATENCY = 2*CB + 4;
	localparam longint      LIMIT   = 400000;

	typedef struct packed {
		logic [CB-1:0] cx;
		logic [CB-1:0] cy;
		logic [CB-1:0] cz;
	} voxel_t;

	typedef struct packed {
		logic [OB-1:0] offset;
		logic          oor;
	} addr_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bricked_volume_address_gen_core #(.COORD_BITS(CB), .OFFSET_BITS(OB)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the brick registers
	logic [bvag_pkg::IEDGE_W-1:0] sh_inner;
	logic [bvag_pkg::OEDGE_W-1:0] sh_outer;
	logic [bvag_pkg::SIZE_W-1:0]  sh_sx, sh_sy, sh_sz, sh_sby, sh_sbz;

	voxel_t pending_voxels[$];
	addr_t  expected_addrs[$];
	int     fail_count = 0;
	longint cycle = 0;
	bit     calm = 0;        // no idling near the end
	bit     long_hold = 0;   // request for a long result-side hold-off

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offset of one voxel in the bricked layout
	function automatic addr_t bricked_offset(voxel_t v);
		addr_t       r;
		longint unsigned e, o, b, sb, x, y, z;
		longint unsigned fx, mx, sx, fy, my, sy, fz, mz, sz, off;
		e = (sh_inner == 0) ? 1 : sh_inner;
		o = (sh_outer == 0) ? 1 : sh_outer;
		b = e*e*e;
		sb = o*o*o*b;
		x = v.cx; y = v.cy; z = v.cz;
		r = '0;
		if (x >= sh_sx || y >= sh_sy || z >= sh_sz) begin
			r.oor = 1'b1;
			return r;
		end
		fx = x % e; mx = (x / e) % o; sx = (x / e) / o;
		fy = y % e; my = (y / e) % o; sy = (y / e) / o;
		fz = z % e; mz = (z / e) % o; sz = (z / e) / o;
		off = sx*sh_sby*sh_sbz*sb + mx*o*o*b + fx*e*e
			+ sy*sh_sbz*sb + my*o*b + fy*e
			+ sz*sb + mz*b + fz;
		r.offset = off[OB-1:0];
		return r;
	endfunction

	// stream driver: random bursts of idle, fed from the pending queue
	int src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_addrs.push_back(bricked_offset(pending_voxels.pop_front()));
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(1, 9) - 1;
					s_tvalid <= 1'b0;
				end else if (pending_voxels.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_voxels[0].cz, pending_voxels[0].cy,
						pending_voxels[0].cx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready idling
	int sink_gap = 0;
	always @(posedge clk) begin
		addr_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_addrs.size() == 0) begin
					$display("%0t: unexpected word off=%0h oor=%0b", $time,
						m_tdata[OB-1:0], m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_addrs.pop_front();
					if (m_tdata[OB-1:0] !== want.offset || m_tuser !== want.oor ||
						m_tdata[39:OB] !== '0) begin
						$display("%0t: expected off=%0h oor=%0b, got off=%0h oor=%0b",
							$time, want.offset, want.oor, m_tdata, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (long_hold) begin
				sink_gap <= 300;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				sink_gap <= $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			bvag_pkg::REG_INNER_EDGE: sh_inner = val[bvag_pkg::IEDGE_W-1:0];
			bvag_pkg::REG_OUTER_EDGE: sh_outer = val[bvag_pkg::OEDGE_W-1:0];
			bvag_pkg::REG_SIZE_X:     sh_sx = val[bvag_pkg::SIZE_W-1:0];
			bvag_pkg::REG_SIZE_Y:     sh_sy = val[bvag_pkg::SIZE_W-1:0];
			bvag_pkg::REG_SIZE_Z:     sh_sz = val[bvag_pkg::SIZE_W-1:0];
			bvag_pkg::REG_SBRICK_Y:   sh_sby = val[bvag_pkg::SIZE_W-1:0];
			bvag_pkg::REG_SBRICK_Z:   sh_sbz = val[bvag_pkg::SIZE_W-1:0];
			default: ;
		endcase
		// let the stride chain settle
		repeat (8) @(posedge clk);
	endtask

	task automatic drain();
		while (pending_voxels.size() > 0 || s_tvalid || expected_addrs.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_layout(int ie, int oe, int sx, int sy, int sz, int by, int bz);
		reg_write(bvag_pkg::REG_INNER_EDGE, ie);
		reg_write(bvag_pkg::REG_OUTER_EDGE, oe);
		reg_write(bvag_pkg::REG_SIZE_X, sx);
		reg_write(bvag_pkg::REG_SIZE_Y, sy);
		reg_write(bvag_pkg::REG_SIZE_Z, sz);
		reg_write(bvag_pkg::REG_SBRICK_Y, by);
		reg_write(bvag_pkg::REG_SBRICK_Z, bz);
	endtask

	function automatic voxel_t rand_voxel(int sx, int sy, int sz);
		voxel_t v;
		// mostly in range, sometimes anywhere
		if ($urandom_range(0, 7) == 0) begin
			v.cx = CB'($urandom); v.cy = CB'($urandom); v.cz = CB'($urandom);
		end else begin
			v.cx = CB'($urandom_range(0, (sx > 4096 ? 4096 : sx) - 1));
			v.cy = CB'($urandom_range(0, (sy > 4096 ? 4096 : sy) - 1));
			v.cz = CB'($urandom_range(0, (sz > 4096 ? 4096 : sz) - 1));
		end
		return v;
	endfunction

	initial begin
		int sx, sy, sz;
		sh_inner = 3; sh_outer = 5; sh_sx = 4096; sh_sy = 4096; sh_sz = 4096;
		sh_sby = 1; sh_sbz = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (8) @(posedge clk);

		// directed: reset layout, corners and range edges
		pending_voxels.push_back('{0, 0, 0});
		pending_voxels.push_back('{4095, 4095, 4095});
		pending_voxels.push_back('{2, 2, 2});
		pending_voxels.push_back('{3, 14, 15});
		pending_voxels.push_back('{12'hAAA, 12'h555, 12'hFFF});
		drain();

		set_layout(8, 32, 4096, 4096, 4096, 4096, 4096);
		pending_voxels.push_back('{4095, 4095, 4095});
		pending_voxels.push_back('{255, 256, 257});
		pending_voxels.push_back('{12'h555, 12'hAAA, 12'h0F0});
		drain();

		// zero edges, zero counts, small and zero sizes
		set_layout(0, 0, 100, 50, 20, 0, 0);
		pending_voxels.push_back('{99, 49, 19});
		pending_voxels.push_back('{100, 0, 0});
		pending_voxels.push_back('{0, 50, 0});
		pending_voxels.push_back('{0, 0, 20});
		pending_voxels.push_back('{7, 9, 11});
		drain();
		set_layout(1, 1, 0, 1, 1, 1, 1);
		pending_voxels.push_back('{0, 0, 0});
		pending_voxels.push_back('{1, 0, 0});
		drain();
		reg_write(3'd7, 32'h5); // unused index, ignored

		// long result-side hold-off while input keeps coming
		set_layout(4, 2, 1000, 900, 800, 3, 5);
		for (int i = 0; i < 60; i++) pending_voxels.push_back(rand_voxel(1000, 900, 800));
		long_hold = 1;
		repeat (2) @(posedge clk);
		long_hold = 0;
		drain();

		// random phases over several layouts
		for (int ph = 0; ph < 6; ph++) begin
			sx = $urandom_range(1, 4096); sy = $urandom_range(1, 4096);
			sz = $urandom_range(1, 4096);
			set_layout($urandom_range(0, 15), $urandom_range(0, 63), sx, sy, sz,
				$urandom_range(0, 8191), $urandom_range(0, 8191));
			if (ph == 5) calm = 1;
			for (int i = 0; i < 55; i++) pending_voxels.push_back(rand_voxel(sx, sy, sz));
			drain();
		end

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

[bricked_volume_address_gen_core.f]
hw/rtl/bvag_pkg.sv
hw/rtl/bvag_div.sv
hw/rtl/bvag_mac.sv
hw/rtl/bricked_volume_address_gen_core.sv
dv/bricked_volume_address_gen_core_tb.sv
